// ----- rtl/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Shared widths, command codes and the control/status bundles between the
// sequencer and the datapath.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int MAP_WORDS_DEF = 64;

    localparam int CMD_W = 2;
    localparam int CNT_W = 12;
    localparam int IDX_W = 11;
    localparam int AWR_W = 7;

    localparam logic [CMD_W-1:0] CMD_ALLOC    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE_ALL = 2'd2;
    localparam logic [CMD_W-1:0] CMD_COUNT    = 2'd3;

    // sequencer -> datapath
    typedef struct packed {
        logic load;
        logic fail;
        logic rd_i;
        logic rd_i1;
        logic rd_j;
        logic inc_i;
        logic inc_j;
        logic wr_small;
        logic save_small;
        logic wr_top;
        logic set_hint_i;
        logic set_hint_i1;
        logic lg_init;
        logic lg_zero;
        logic lg_nz;
        logic lg_fill;
        logic wr_or;
        logic free_init;
        logic wr_and_one;
        logic wr_and_s;
        logic wr_and_e;
        logic wr_zero;
        logic cnt_add;
        logic clear_all;
        logic push;
    } bba_ctl_t;

    // datapath -> sequencer
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic n_zero;
        logic n_small;
        logic free_oob;
        logic free_one;
        logic j_lt_ew;
        logic ew_in;
        logic i_end;
        logic i1_ok;
        logic j_end;
        logic e_full;
        logic fit_any;
        logic k_pos;
        logic e2_ok;
        logic le_zero;
        logic avail_ok;
        logic rest_big;
        logic endm_nz;
        logic out_free;
    } bba_sts_t;

endpackage

// ----- rtl/bba_req_if.sv -----
// ----------------------------------------------------------------------------
// Allocator request channel
// valid/ready channel carrying one command with its count and index.
// ----------------------------------------------------------------------------
interface bba_req_if import bba_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [CNT_W-1:0] block_count;
    logic [IDX_W-1:0] block_index;

    modport source (output valid, output cmd, output block_count, output block_index,
                    input ready);
    modport sink (input valid, input cmd, input block_count, input block_index,
                  output ready);
endinterface

// ----- rtl/bba_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Allocator response channel
// valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface bba_rsp_if import bba_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             status;
    logic [IDX_W-1:0] first_block;
    logic [CNT_W-1:0] used_count;

    modport source (output valid, output status, output first_block, output used_count,
                    input ready);
    modport sink (input valid, input status, input first_block, input used_count,
                  output ready);
endinterface

// ----- rtl/bba_datapath.sv -----
// ----------------------------------------------------------------------------
// Allocator datapath
// Bitmap memory with per-word valid bits, word/search registers, fit logic,
// popcount accumulator and the response register.
// ----------------------------------------------------------------------------
module bba_datapath import bba_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int MAP_WORDS = MAP_WORDS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CMD_W-1:0] req_cmd,
    input  logic [CNT_W-1:0] req_count,
    input  logic [IDX_W-1:0] req_index,
    input  logic             cfg_we,
    input  logic [AWR_W-1:0] cfg_wdata,
    input  bba_ctl_t         ctl,
    output bba_sts_t         sts,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output logic             rsp_status,
    output logic [IDX_W-1:0] rsp_first,
    output logic [CNT_W-1:0] rsp_used
);

    localparam int LG  = $clog2(WORD_BITS);
    localparam int AW  = $clog2(MAP_WORDS);
    localparam int WC  = $clog2(MAP_WORDS + 1);
    localparam int HW  = $clog2(MAP_WORDS);
    localparam int KW  = LG + 1;
    localparam int AVW = $clog2(MAP_WORDS * WORD_BITS + WORD_BITS + 1);

    function automatic logic [WORD_BITS-1:0] low_mask(input int unsigned x);
        logic [WORD_BITS-1:0] ones;
        ones = '1;
        if (x == 0)
        begin
            return '0;
        end
        return ones >> (WORD_BITS - x);
    endfunction

    logic [WORD_BITS-1:0] mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] valid_reg;

    logic [CMD_W-1:0]     cmd_reg;
    logic [CNT_W-1:0]     n_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [WC-1:0]        i_reg;
    logic [WC-1:0]        j_reg;
    logic [HW-1:0]        hint_reg;
    logic [HW-1:0]        hint_next;
    logic [WC-1:0]        aw_reg;
    logic [WC-1:0]        aw_next;
    logic [WORD_BITS-1:0] rdata_reg;
    logic [WORD_BITS-1:0] e_reg;
    logic [KW-1:0]        k_reg;
    logic [WORD_BITS-1:0] endm_reg;
    logic [LG-1:0]        tail_reg;
    logic [AVW-1:0]       avail_reg;
    logic [CNT_W-1:0]     rest_reg;
    logic                 status_reg;
    logic [IDX_W-1:0]     first_reg;
    logic [CNT_W-1:0]     used_reg;
    logic                 out_valid_reg;
    logic                 out_status_reg;
    logic [IDX_W-1:0]     out_first_reg;
    logic [CNT_W-1:0]     out_used_reg;

    logic [KW-1:0]        tz_cur;
    logic                 n_small;
    logic [WORD_BITS-1:0] mask_n;
    logic                 fit_any;
    logic [LG-1:0]        fit_pos;
    logic [LG-1:0]        tail_cur;
    logic [CNT_W:0]       endb;
    logic [31:0]          sw;
    logic [31:0]          ew;
    logic [WORD_BITS-1:0] smask;
    logic [WORD_BITS-1:0] emask;
    logic [LG:0]          popcnt;
    logic                 rd_en;
    logic [WC-1:0]        rd_addr;
    logic                 we;
    logic [WC-1:0]        waddr;
    logic [WORD_BITS-1:0] wdata;

    // leading zeros of the word just read: free top bits
    always_comb
    begin
        tz_cur = KW'(WORD_BITS);
        for (int b = 0; b < WORD_BITS; b++)
        begin
            if (rdata_reg[b])
            begin
                tz_cur = KW'(WORD_BITS - 1 - b);
            end
        end
    end

    assign n_small  = (n_reg < CNT_W'(WORD_BITS));
    assign mask_n   = n_small ? low_mask(int'(n_reg[LG-1:0])) : '0;
    assign tail_cur = n_reg[LG-1:0] - tz_cur[LG-1:0];

    // lowest start position below word-n whose run is all free
    always_comb
    begin
        fit_any = 1'b0;
        fit_pos = '0;
        for (int s = WORD_BITS - 1; s >= 0; s--)
        begin
            if ((s < WORD_BITS - int'(n_reg)) && ((rdata_reg & (mask_n << s)) == '0))
            begin
                fit_any = 1'b1;
                fit_pos = LG'(s);
            end
        end
    end

    always_comb
    begin
        popcnt = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            popcnt = popcnt + (LG + 1)'(rdata_reg[b]);
        end
    end

    assign endb  = (CNT_W + 1)'(idx_reg) + (CNT_W + 1)'(n_reg);
    assign sw    = 32'(idx_reg) >> LG;
    assign ew    = 32'(endb) >> LG;
    assign smask = low_mask(int'(idx_reg[LG-1:0]));
    assign emask = ~low_mask(int'(endb[LG-1:0]));

    always_comb
    begin
        sts.cmd      = cmd_reg;
        sts.n_zero   = (n_reg == '0);
        sts.n_small  = n_small;
        sts.free_oob = (32'(endb) > (32'(aw_reg) << LG));
        sts.free_one = (sw == ew);
        sts.j_lt_ew  = (32'(j_reg) < ew);
        sts.ew_in    = (ew < 32'(aw_reg));
        sts.i_end    = (i_reg >= aw_reg);
        sts.i1_ok    = ((32'(i_reg) + 32'd1) < 32'(aw_reg));
        sts.j_end    = (j_reg >= aw_reg);
        sts.e_full   = &rdata_reg;
        sts.fit_any  = fit_any;
        sts.k_pos    = (tz_cur != '0);
        sts.e2_ok    = ((rdata_reg & endm_reg) == '0);
        sts.le_zero  = (rdata_reg == '0);
        sts.avail_ok = (32'(avail_reg) >= 32'(n_reg));
        sts.rest_big = (rest_reg >= CNT_W'(WORD_BITS));
        sts.endm_nz  = (endm_reg != '0);
        sts.out_free = !out_valid_reg || rsp_ready;
    end

    // read port
    always_comb
    begin
        rd_en   = ctl.rd_i || ctl.rd_i1 || ctl.rd_j;
        rd_addr = j_reg;
        if (ctl.rd_i)
        begin
            rd_addr = i_reg;
        end
        else if (ctl.rd_i1)
        begin
            rd_addr = i_reg + WC'(1);
        end
    end

    // write port
    always_comb
    begin
        we    = 1'b1;
        waddr = j_reg;
        wdata = '0;
        if (ctl.wr_small)
        begin
            waddr = i_reg;
            wdata = rdata_reg | (mask_n << fit_pos);
        end
        else if (ctl.wr_top)
        begin
            waddr = i_reg;
            wdata = e_reg | ~low_mask(WORD_BITS - int'(k_reg));
        end
        else if (ctl.wr_or)
        begin
            wdata = rdata_reg | endm_reg;
        end
        else if (ctl.lg_fill)
        begin
            wdata = '1;
        end
        else if (ctl.wr_and_one)
        begin
            wdata = rdata_reg & (smask | emask);
        end
        else if (ctl.wr_and_s)
        begin
            wdata = rdata_reg & smask;
        end
        else if (ctl.wr_and_e)
        begin
            wdata = rdata_reg & emask;
        end
        else if (!ctl.wr_zero)
        begin
            we = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr[AW-1:0]] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= valid_reg[rd_addr[AW-1:0]] ? mem[rd_addr[AW-1:0]] : '0;
        end
    end

    // a word never written since reset or free-all reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctl.clear_all)
        begin
            for (int w = 0; w < MAP_WORDS; w++)
            begin
                if (WC'(w) < aw_reg)
                begin
                    valid_reg[w] <= 1'b0;
                end
            end
        end
        else if (we)
        begin
            valid_reg[waddr[AW-1:0]] <= 1'b1;
        end
    end

    always_comb
    begin
        int v;
        v         = int'(cfg_wdata);
        aw_next   = aw_reg;
        hint_next = hint_reg;
        if (cfg_we)
        begin
            if (v == 0)
            begin
                v = 1;
            end
            if (v > MAP_WORDS)
            begin
                v = MAP_WORDS;
            end
            aw_next = WC'(v);
            if (32'(hint_reg) >= 32'(v))
            begin
                hint_next = '0;
            end
        end
        else if (ctl.free_init)
        begin
            if (32'(hint_reg) > sw)
            begin
                hint_next = HW'(sw);
            end
        end
        else if (ctl.wr_small || ctl.set_hint_i)
        begin
            hint_next = HW'(i_reg);
        end
        else if (ctl.set_hint_i1)
        begin
            hint_next = HW'(i_reg + WC'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aw_reg        <= WC'(MAP_WORDS);
            hint_reg      <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            aw_reg   <= aw_next;
            hint_reg <= hint_next;
            if (ctl.load)
            begin
                i_reg <= WC'(hint_reg);
            end
            else if (ctl.inc_i)
            begin
                i_reg <= i_reg + WC'(1);
            end
            if (ctl.load)
            begin
                j_reg <= '0;
            end
            else if (ctl.free_init)
            begin
                j_reg <= WC'(sw);
            end
            else if (ctl.save_small || ctl.lg_init || ctl.wr_top)
            begin
                j_reg <= i_reg + WC'(1);
            end
            else if (ctl.inc_j)
            begin
                j_reg <= j_reg + WC'(1);
            end
            if (ctl.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg    <= req_cmd;
            n_reg      <= req_count;
            idx_reg    <= req_index;
            status_reg <= 1'b0;
            first_reg  <= '0;
            used_reg   <= '0;
        end
        if (ctl.fail)
        begin
            status_reg <= 1'b1;
            first_reg  <= '0;
        end
        if (ctl.wr_small)
        begin
            first_reg <= IDX_W'((32'(i_reg) << LG) + 32'(fit_pos));
        end
        if (ctl.wr_top)
        begin
            first_reg <= IDX_W'((32'(i_reg) << LG) + 32'(WORD_BITS) - 32'(k_reg));
            rest_reg  <= n_reg - CNT_W'(k_reg);
        end
        if (ctl.lg_fill)
        begin
            rest_reg <= rest_reg - CNT_W'(WORD_BITS);
        end
        if (ctl.save_small)
        begin
            e_reg    <= rdata_reg;
            k_reg    <= tz_cur;
            endm_reg <= mask_n >> tz_cur;
        end
        if (ctl.lg_init)
        begin
            e_reg     <= rdata_reg;
            k_reg     <= tz_cur;
            tail_reg  <= tail_cur;
            endm_reg  <= low_mask(int'(tail_cur));
            avail_reg <= AVW'(tz_cur);
        end
        if (ctl.lg_zero)
        begin
            avail_reg <= avail_reg + AVW'(WORD_BITS);
        end
        if (ctl.lg_nz && ((rdata_reg & endm_reg) == '0))
        begin
            avail_reg <= avail_reg + AVW'(tail_reg);
        end
        if (ctl.cnt_add)
        begin
            used_reg <= used_reg + CNT_W'(popcnt);
        end
        if (ctl.push)
        begin
            out_status_reg <= status_reg;
            out_first_reg  <= first_reg;
            out_used_reg   <= used_reg;
        end
    end

    assign rsp_valid  = out_valid_reg;
    assign rsp_status = out_status_reg;
    assign rsp_first  = out_first_reg;
    assign rsp_used   = out_used_reg;

endmodule

// ----- rtl/bba_ctrl.sv -----
// ----------------------------------------------------------------------------
// Allocator sequencer
// Walks the bitmap words for each request and drives the datapath.
// ----------------------------------------------------------------------------
module bba_ctrl import bba_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    output bba_ctl_t ctl,
    input  bba_sts_t sts
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISP,
        S_A_CHK,
        S_A_EVAL,
        S_A_EVAL2,
        S_A_WR2,
        S_L_SCAN,
        S_L_SEE,
        S_L_DEC,
        S_L_FILL,
        S_L_END,
        S_F_HEAD,
        S_F_ONE,
        S_F_FIRST,
        S_F_MID,
        S_F_LAST,
        S_C_START,
        S_C_RUN,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && ready_reg)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (sts.cmd)
                    CMD_ALLOC:
                    begin
                        if (sts.n_zero)
                        begin
                            ctl.fail   = 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_A_CHK;
                        end
                    end
                    CMD_FREE:
                    begin
                        if (sts.free_oob)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            ctl.free_init = 1'b1;
                            state_next    = S_F_HEAD;
                        end
                    end
                    CMD_FREE_ALL:
                    begin
                        ctl.clear_all = 1'b1;
                        state_next    = S_DONE;
                    end
                    CMD_COUNT:
                    begin
                        state_next = S_C_START;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_A_CHK:
            begin
                if (sts.i_end)
                begin
                    ctl.fail   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    ctl.rd_i   = 1'b1;
                    state_next = S_A_EVAL;
                end
            end
            S_A_EVAL:
            begin
                if (sts.e_full)
                begin
                    ctl.inc_i  = 1'b1;
                    state_next = S_A_CHK;
                end
                else if (!sts.n_small)
                begin
                    ctl.lg_init = 1'b1;
                    state_next  = S_L_SCAN;
                end
                else if (sts.fit_any)
                begin
                    ctl.wr_small = 1'b1;
                    state_next   = S_DONE;
                end
                else if (sts.k_pos && sts.i1_ok)
                begin
                    // try the wrap into the next word
                    ctl.save_small = 1'b1;
                    ctl.rd_i1      = 1'b1;
                    state_next     = S_A_EVAL2;
                end
                else
                begin
                    ctl.inc_i  = 1'b1;
                    state_next = S_A_CHK;
                end
            end
            S_A_EVAL2:
            begin
                if (sts.e2_ok)
                begin
                    ctl.wr_top      = 1'b1;
                    ctl.set_hint_i1 = 1'b1;
                    state_next      = S_A_WR2;
                end
                else
                begin
                    ctl.inc_i  = 1'b1;
                    state_next = S_A_CHK;
                end
            end
            S_A_WR2:
            begin
                ctl.wr_or  = 1'b1;
                state_next = S_DONE;
            end
            S_L_SCAN:
            begin
                if (sts.avail_ok || sts.j_end)
                begin
                    state_next = S_L_DEC;
                end
                else
                begin
                    ctl.rd_j   = 1'b1;
                    state_next = S_L_SEE;
                end
            end
            S_L_SEE:
            begin
                if (sts.le_zero)
                begin
                    ctl.lg_zero = 1'b1;
                    ctl.inc_j   = 1'b1;
                    state_next  = S_L_SCAN;
                end
                else
                begin
                    ctl.lg_nz  = 1'b1;
                    state_next = S_L_DEC;
                end
            end
            S_L_DEC:
            begin
                if (!sts.avail_ok)
                begin
                    ctl.inc_i  = 1'b1;
                    state_next = S_A_CHK;
                end
                else
                begin
                    ctl.wr_top     = 1'b1;
                    ctl.set_hint_i = 1'b1;
                    state_next     = S_L_FILL;
                end
            end
            S_L_FILL:
            begin
                if (sts.rest_big && !sts.j_end)
                begin
                    ctl.lg_fill = 1'b1;
                    ctl.inc_j   = 1'b1;
                end
                else if (sts.endm_nz && !sts.j_end)
                begin
                    ctl.rd_j   = 1'b1;
                    state_next = S_L_END;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_L_END:
            begin
                ctl.wr_or  = 1'b1;
                state_next = S_DONE;
            end
            S_F_HEAD:
            begin
                if (!sts.free_one)
                begin
                    ctl.rd_j   = 1'b1;
                    state_next = S_F_FIRST;
                end
                else if (!sts.j_end)
                begin
                    ctl.rd_j   = 1'b1;
                    state_next = S_F_ONE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_F_ONE:
            begin
                ctl.wr_and_one = 1'b1;
                state_next     = S_DONE;
            end
            S_F_FIRST:
            begin
                ctl.wr_and_s = 1'b1;
                ctl.inc_j    = 1'b1;
                state_next   = S_F_MID;
            end
            S_F_MID:
            begin
                if (sts.j_lt_ew)
                begin
                    ctl.wr_zero = 1'b1;
                    ctl.inc_j   = 1'b1;
                end
                else if (sts.ew_in)
                begin
                    ctl.rd_j   = 1'b1;
                    state_next = S_F_LAST;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_F_LAST:
            begin
                ctl.wr_and_e = 1'b1;
                state_next   = S_DONE;
            end
            S_C_START:
            begin
                if (sts.j_end)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ctl.rd_j   = 1'b1;
                    ctl.inc_j  = 1'b1;
                    state_next = S_C_RUN;
                end
            end
            S_C_RUN:
            begin
                // add the word read last cycle while fetching the next
                ctl.cnt_add = 1'b1;
                if (sts.j_end)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ctl.rd_j  = 1'b1;
                    ctl.inc_j = 1'b1;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    ctl.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

    assign req_ready = ready_reg;

endmodule

// ----- rtl/bitmap_block_allocator.sv -----
// ----------------------------------------------------------------------------
// Bitmap block allocator
// Contiguous block allocation, range free, free-all and used count over a
// word-organized usage bitmap.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    cmd, block_count, block_index
//   rsp      out  valid/ready    status, first_block, used_count
//   cfg      in   cfg_we         cfg_wdata (active words)
//
// One request at a time; bitmap memory has one read and one write port.
// Count reads every active word; free visits the words its range covers; alloc
// scans words, plus those a large run probes and fills. Reset is immediate
// (per-word valid bits, no clearing pass).
// A stalled rsp holds its result; the next request is accepted meanwhile.
// ----------------------------------------------------------------------------
module bitmap_block_allocator import bba_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int MAP_WORDS = MAP_WORDS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    bba_req_if.sink          req,
    bba_rsp_if.source        rsp,
    input  logic             cfg_we,
    input  logic [AWR_W-1:0] cfg_wdata
);

    bba_ctl_t ctl;
    bba_sts_t sts;

    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .ctl       (ctl),
        .sts       (sts)
    );

    bba_datapath #(
        .WORD_BITS (WORD_BITS),
        .MAP_WORDS (MAP_WORDS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_cmd    (req.cmd),
        .req_count  (req.block_count),
        .req_index  (req.block_index),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .ctl        (ctl),
        .sts        (sts),
        .rsp_valid  (rsp.valid),
        .rsp_ready  (rsp.ready),
        .rsp_status (rsp.status),
        .rsp_first  (rsp.first_block),
        .rsp_used   (rsp.used_count)
    );

endmodule

// ----- rtl/bba_checker.sv -----
// ----------------------------------------------------------------------------
// Allocator port checker
// Port-level properties of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bba_checker import bba_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic             rsp_status,
    input logic [IDX_W-1:0] rsp_first,
    input logic [CNT_W-1:0] rsp_used
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second request taken while one is in progress");

    a_fail_first: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status |-> rsp_first == '0)
        else $error("failed allocation reports a block");

    a_fail_used: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status |-> rsp_used == '0)
        else $error("failed allocation reports a used count");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_first  (rsp.first_block),
    .rsp_used   (rsp.used_count)
);
